/* src/mbrc_pkg.sv */
package mbrc_pkg;

    localparam int ADDR_BITS_DEF = 32;
    localparam int OUTQ_DEPTH_DEF = 4;

    localparam logic [2:0] KIND_UNKNOWN    = 3'd0;
    localparam logic [2:0] KIND_ZERO       = 3'd1;
    localparam logic [2:0] KIND_SUPERBLOCK = 3'd2;
    localparam logic [2:0] KIND_INDEX      = 3'd3;
    localparam logic [2:0] KIND_BITMAP     = 3'd4;
    localparam logic [2:0] KIND_NODE       = 3'd5;

    localparam logic [1:0] NODE_FLAG_MASK = 2'h3;

    typedef struct packed {
        logic p0;
        logic p1;
    } t_push;

    function automatic logic kind_has_blocknr(input logic [2:0] kind);
        return (kind == KIND_SUPERBLOCK) || (kind == KIND_INDEX) ||
               (kind == KIND_BITMAP) || (kind == KIND_NODE);
    endfunction

    function automatic logic kind_is_node(input logic [2:0] kind);
        return kind == KIND_NODE;
    endfunction

endpackage

/* src/metadata_block_run_coalescer.sv */
// items are registered in the input stage; closed runs pass through the result queue
// throughput: one item per cycle while each item closes at most one run and the
//   output is ready; an item that both closes a run and ends the scan emits two
//   runs, which drain from the 4-entry result queue at one per cycle
// reset: synchronous, active low; clears the input stage, the open run and the queue
module metadata_block_run_coalescer #(
    parameter int ADDR_BITS = mbrc_pkg::ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_block_kind,
    input  logic [ADDR_BITS-1:0] i_location,
    input  logic [63:0]          i_header_blocknr,
    input  logic signed [32:0]   i_ref_count,
    input  logic                 i_valid_req,
    input  logic [1:0]           i_node_flags,
    input  logic [11:0]          i_value_size,
    input  logic                 i_last_block,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0]           o_run_kind,
    output logic [ADDR_BITS-1:0] o_run_begin,
    output logic [ADDR_BITS:0]   o_run_length,
    output logic [63:0]          o_run_blocknr,
    output logic signed [32:0]   o_run_ref_count,
    output logic                 o_run_valid,
    output logic [1:0]           o_run_flags,
    output logic [11:0]          o_run_value_size,
    output logic                 o_last_run
);
    import mbrc_pkg::*;

    typedef struct packed {
        logic [2:0]           kind;
        logic [ADDR_BITS-1:0] rbegin;
        logic [ADDR_BITS:0]   length;
        logic [63:0]          blocknr;
        logic [32:0]          rc;
        logic                 valid;
        logic [1:0]           flags;
        logic [11:0]          vsize;
        logic                 last;
    } t_run_rec;

    localparam int REC_W = $bits(t_run_rec);

    // input stage
    logic                 r_in_valid;
    logic [2:0]           r_in_kind;
    logic [ADDR_BITS-1:0] r_in_loc;
    logic [63:0]          r_in_hb;
    logic [32:0]          r_in_rc;
    logic                 r_in_v;
    logic [1:0]           r_in_fl;
    logic [11:0]          r_in_vs;
    logic                 r_in_last;

    // open run
    logic                 r_open, n_open;
    logic [2:0]           r_kind, n_kind;
    logic [ADDR_BITS-1:0] r_begin, n_begin;
    logic [ADDR_BITS:0]   r_end, n_end;
    logic [ADDR_BITS:0]   r_len, n_len;
    logic [63:0]          r_blocknr, n_blocknr;
    logic [64:0]          r_exp, n_exp;
    logic [32:0]          r_rc, n_rc;
    logic                 r_valid, n_valid;
    logic [1:0]           r_flags, n_flags;
    logic [11:0]          r_vsize, n_vsize;

    logic     q_space;
    logic     go;
    logic     same;
    logic     extra;
    logic     hasbn;
    logic     right;
    logic     left;
    logic     close;
    t_push    push;
    t_run_rec rec_close;
    t_run_rec rec_final;
    t_run_rec rec_out;
    logic [REC_W-1:0] q_data;

    assign go      = r_in_valid && q_space;
    assign o_ready = !r_in_valid || q_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_kind <= i_block_kind;
            r_in_loc  <= i_location;
            r_in_hb   <= i_header_blocknr;
            r_in_rc   <= i_ref_count;
            r_in_v    <= i_valid_req;
            r_in_fl   <= i_node_flags & NODE_FLAG_MASK;
            r_in_vs   <= i_value_size;
            r_in_last <= i_last_block;
        end
    end

    // adjacency against the open run
    assign hasbn = kind_has_blocknr(r_in_kind);
    assign same  = (r_in_kind == r_kind) && (r_in_rc == r_rc) && (r_in_v == r_valid);
    assign extra = kind_is_node(r_in_kind) ?
                   ((r_in_fl == r_flags) && (r_in_vs == r_vsize)) : 1'b1;
    assign right = r_open && same && extra && ({1'b0, r_in_loc} == r_end) &&
                   (!hasbn || (!r_exp[64] && (r_in_hb == r_exp[63:0])));
    assign left  = r_open && same && extra && (r_begin != '0) &&
                   (r_in_loc == r_begin - ADDR_BITS'(1)) &&
                   (!hasbn || ((r_blocknr != 64'd0) && (r_in_hb == r_blocknr - 64'd1)));

    always_comb begin
        n_open    = r_open;
        n_kind    = r_kind;
        n_begin   = r_begin;
        n_end     = r_end;
        n_len     = r_len;
        n_blocknr = r_blocknr;
        n_exp     = r_exp;
        n_rc      = r_rc;
        n_valid   = r_valid;
        n_flags   = r_flags;
        n_vsize   = r_vsize;
        close     = 1'b0;
        if (go) begin
            if (right) begin
                n_end = {1'b0, r_in_loc} + (ADDR_BITS+1)'(1);
                n_len = r_len + (ADDR_BITS+1)'(1);
                n_exp = r_exp + 65'd1;
            end else if (left) begin
                n_begin = r_in_loc;
                n_len   = r_len + (ADDR_BITS+1)'(1);
                if (hasbn) begin
                    n_blocknr = r_in_hb;
                end
            end else begin
                close     = r_open;
                n_open    = 1'b1;
                n_kind    = r_in_kind;
                n_begin   = r_in_loc;
                n_end     = {1'b0, r_in_loc} + (ADDR_BITS+1)'(1);
                n_len     = (ADDR_BITS+1)'(1);
                n_blocknr = hasbn ? r_in_hb : 64'd0;
                n_exp     = {1'b0, r_in_hb} + 65'd1;
                n_rc      = r_in_rc;
                n_valid   = r_in_v;
                n_flags   = kind_is_node(r_in_kind) ? r_in_fl : 2'd0;
                n_vsize   = kind_is_node(r_in_kind) ? r_in_vs : 12'd0;
            end
            if (r_in_last) begin
                n_open = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else begin
            r_open <= n_open;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_begin   <= n_begin;
        r_end     <= n_end;
        r_len     <= n_len;
        r_blocknr <= n_blocknr;
        r_exp     <= n_exp;
        r_rc      <= n_rc;
        r_valid   <= n_valid;
        r_flags   <= n_flags;
        r_vsize   <= n_vsize;
    end

    always_comb begin
        rec_close.kind    = r_kind;
        rec_close.rbegin  = r_begin;
        rec_close.length  = r_len;
        rec_close.blocknr = r_blocknr;
        rec_close.rc      = r_rc;
        rec_close.valid   = r_valid;
        rec_close.flags   = r_flags;
        rec_close.vsize   = r_vsize;
        rec_close.last    = 1'b0;

        rec_final.kind    = n_kind;
        rec_final.rbegin  = n_begin;
        rec_final.length  = n_len;
        rec_final.blocknr = n_blocknr;
        rec_final.rc      = n_rc;
        rec_final.valid   = n_valid;
        rec_final.flags   = n_flags;
        rec_final.vsize   = n_vsize;
        rec_final.last    = 1'b1;
    end

    assign push.p0 = close;
    assign push.p1 = go && r_in_last;

    mbrc_outq #(
        .WIDTH (REC_W),
        .DEPTH (OUTQ_DEPTH_DEF)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data0 (rec_close),
        .i_data1 (rec_final),
        .o_space (q_space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (q_data)
    );

    assign rec_out          = t_run_rec'(q_data);
    assign o_run_kind       = rec_out.kind;
    assign o_run_begin      = rec_out.rbegin;
    assign o_run_length     = rec_out.length;
    assign o_run_blocknr    = rec_out.blocknr;
    assign o_run_ref_count  = rec_out.rc;
    assign o_run_valid      = rec_out.valid;
    assign o_run_flags      = rec_out.flags;
    assign o_run_value_size = rec_out.vsize;
    assign o_last_run       = rec_out.last;

    a_end_tracks_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_end == ({1'b0, r_begin} + r_len)))
        else $error("open run end does not match begin plus length");

    a_exp_tracks_blocknr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_open && kind_has_blocknr(r_kind)) |->
            (r_exp == ({1'b0, r_blocknr} + 65'(r_len))))
        else $error("expected header block number out of step with run");

    a_last_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && r_in_last) |=> !r_open)
        else $error("run still open after end of scan");

    a_no_close_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.p0 |-> (go && $past(1'b1) && r_open))
        else $error("run closed without an item or an open run");

endmodule

/* src/mbrc_outq.sv */
module mbrc_outq #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mbrc_pkg::OUTQ_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbrc_pkg::t_push   i_push,
    input  logic [WIDTH-1:0]  i_data0,
    input  logic [WIDTH-1:0]  i_data1,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WIDTH-1:0]  o_data
);
    import mbrc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = AW + 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    wr1;
    logic             pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];
    assign o_space = r_count <= CW'(DEPTH - 2);
    assign wr1     = r_wr + AW'(i_push.p0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + AW'(i_push.p0) + AW'(i_push.p1);
            r_rd    <= r_rd + AW'(pop);
            r_count <= r_count + CW'(i_push.p0) + CW'(i_push.p1) - CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.p0) begin
            r_mem[r_wr] <= i_data0;
        end
        if (i_push.p1) begin
            r_mem[wr1] <= i_data1;
        end
    end

endmodule
